FILE: src/wrm_pkg.sv
// Shared types and constants of the windowed rate average meter.
// Depends on nothing; every other file of the block imports it.
package wrm_pkg;

	// Sizing of the ring and the time base.
	localparam int WINDOW_SLOTS     = 30;
	localparam int TICKS_PER_SECOND = 1000;

	localparam int SUM_W   = 64;
	localparam int VAL_W   = 32;
	localparam int TIME_W  = 32;
	localparam int CNT_W   = 32;
	localparam int FILL_W  = $clog2(WINDOW_SLOTS + 1);
	localparam int PTR_W   = (WINDOW_SLOTS > 1) ? $clog2(WINDOW_SLOTS) : 1;
	localparam int STEPS_W = $clog2(SUM_W + 1);

	// Whole seconds are found by a multiplication with a rounded-up reciprocal.
	// With the shift set to 32 plus the ceiling of log2 of the divisor, the
	// quotient is exact for every 32-bit elapsed time.
	localparam int SEC_SHIFT = TIME_W + $clog2(TICKS_PER_SECOND);
	localparam int MAGIC_W   = TIME_W + 1;
	localparam int PROD_W    = TIME_W + MAGIC_W;
	localparam logic [63:0] SEC_MAGIC_FULL =
		((64'd1 << SEC_SHIFT) + 64'(TICKS_PER_SECOND) - 64'd1) / 64'(TICKS_PER_SECOND);
	localparam logic [MAGIC_W-1:0] SEC_MAGIC = SEC_MAGIC_FULL[MAGIC_W-1:0];

	localparam logic [PTR_W-1:0]  LAST_SLOT = PTR_W'(WINDOW_SLOTS - 1);
	localparam logic [FILL_W-1:0] FULL_FILL = FILL_W'(WINDOW_SLOTS);

	// One input beat.
	typedef struct packed {
		logic [VAL_W-1:0]  sample_value;
		logic [TIME_W-1:0] now_ms;
	} in_beat_t;

	// One result beat.
	typedef struct packed {
		logic [SUM_W-1:0] rolling_average;
		logic             window_closed;
	} out_beat_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic accept;      // take an input beat, accumulate and count it
		logic mul_en;      // form the reciprocal product of the elapsed time
		logic div1_start;  // start the interval value division
		logic ring_upd;    // push the interval value and start the average division
		logic close;       // keep the new average and restart the interval
		logic out_load;    // load the output register
		logic out_closed;  // window_closed flag for the loaded result
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic secs_nz;   // at least one whole second has passed
		logic div_done;  // the divider quotient is ready
		logic out_busy;  // the output register holds a beat that is stalled
	} stat_t;

endpackage

FILE: src/wrm_div.sv
// Iterative restoring divider, one quotient bit per cycle.
// Depends on wrm_pkg.
module wrm_div (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic [wrm_pkg::SUM_W-1:0] dividend,
	input  logic [wrm_pkg::SUM_W-1:0] divisor,
	output logic [wrm_pkg::SUM_W-1:0] quotient,
	output logic                      done
);
	import wrm_pkg::*;

	logic [SUM_W-1:0]   rem_q;
	logic [SUM_W-1:0]   dq_q;
	logic [SUM_W-1:0]   div_q;
	logic [STEPS_W-1:0] steps_q;
	logic               busy_q;
	logic               done_q;
	logic [SUM_W:0]     rem_sh;
	logic [SUM_W:0]     diff;

	// Shift in the next dividend bit and try to subtract the divisor.
	assign rem_sh = {rem_q, dq_q[SUM_W-1]};
	assign diff   = rem_sh - {1'b0, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			done_q  <= 1'b0;
			steps_q <= '0;
		end else if (start) begin
			busy_q  <= 1'b1;
			done_q  <= 1'b0;
			steps_q <= STEPS_W'(SUM_W);
		end else if (busy_q) begin
			steps_q <= steps_q - 1'b1;
			if (steps_q == STEPS_W'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			dq_q  <= dividend;
			div_q <= divisor;
		end else if (busy_q) begin
			if (!diff[SUM_W]) begin
				rem_q <= diff[SUM_W-1:0];
				dq_q  <= {dq_q[SUM_W-2:0], 1'b1};
			end else begin
				rem_q <= rem_sh[SUM_W-1:0];
				dq_q  <= {dq_q[SUM_W-2:0], 1'b0};
			end
		end
	end

	assign quotient = dq_q;
	assign done     = done_q;

endmodule

FILE: src/wrm_dp.sv
// Datapath: interval accumulator, seconds multiplier, ring store, divider, output register.
// Depends on wrm_pkg and wrm_div.
module wrm_dp (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic               cfg_wdata,
	input  wrm_pkg::in_beat_t  in_data,
	output wrm_pkg::out_beat_t out_data,
	output logic               out_valid,
	input  logic               out_stall,
	input  wrm_pkg::cmd_t      cmd,
	output wrm_pkg::stat_t     stat
);
	import wrm_pkg::*;

	logic               per_time_unit_q;
	logic [SUM_W-1:0]   sum_q;
	logic [CNT_W-1:0]   count_q;
	logic [TIME_W-1:0]  start_q;
	logic [TIME_W-1:0]  now_q;
	logic [TIME_W-1:0]  elapsed_q;
	logic [PROD_W-1:0]  prod_s1;
	logic [TIME_W-1:0]  secs;
	logic [SUM_W-1:0]   ring_mem [WINDOW_SLOTS];
	logic [SUM_W-1:0]   slot_rd_q;
	logic [FILL_W-1:0]  fill_q;
	logic [FILL_W-1:0]  fill_new;
	logic [PTR_W-1:0]   wp_q;
	logic [SUM_W-1:0]   total_q;
	logic [SUM_W-1:0]   total_new;
	logic [SUM_W-1:0]   avg_q;
	logic               ring_full;
	logic               out_valid_q;
	out_beat_t          out_q;
	logic               div_start;
	logic [SUM_W-1:0]   div_dividend;
	logic [SUM_W-1:0]   div_divisor;
	logic [SUM_W-1:0]   div_quot;
	logic               div_done;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			per_time_unit_q <= 1'b1;
		end else if (cfg_we) begin
			per_time_unit_q <= cfg_wdata;
		end
	end

	assign secs      = TIME_W'(prod_s1 >> SEC_SHIFT);
	assign ring_full = (fill_q == FULL_FILL);
	assign fill_new  = ring_full ? fill_q : fill_q + 1'b1;
	assign total_new = ring_full ? total_q - slot_rd_q + div_quot : total_q + div_quot;

	// The divider is shared by the interval value and the rolling average.
	assign div_start    = cmd.div1_start | cmd.ring_upd;
	assign div_dividend = cmd.ring_upd ? total_new : sum_q;
	always_comb begin
		priority if (cmd.ring_upd) begin
			div_divisor = SUM_W'(fill_new);
		end else if (per_time_unit_q) begin
			div_divisor = SUM_W'(secs);
		end else begin
			div_divisor = SUM_W'(count_q);
		end
	end

	wrm_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.quotient (div_quot),
		.done     (div_done)
	);

	// Interval state and ring bookkeeping.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q   <= '0;
			count_q <= '0;
			start_q <= '0;
			fill_q  <= '0;
			wp_q    <= '0;
			total_q <= '0;
			avg_q   <= '0;
		end else begin
			if (cmd.accept) begin
				sum_q <= sum_q + SUM_W'(in_data.sample_value);
				if (count_q != '1) begin
					count_q <= count_q + 1'b1;
				end
			end
			if (cmd.ring_upd) begin
				total_q <= total_new;
				fill_q  <= fill_new;
				wp_q    <= (wp_q == LAST_SLOT) ? '0 : wp_q + 1'b1;
			end
			if (cmd.close) begin
				avg_q   <= div_quot;
				sum_q   <= '0;
				count_q <= '0;
				start_q <= now_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			now_q     <= in_data.now_ms;
			elapsed_q <= in_data.now_ms - start_q;
		end
		if (cmd.mul_en) begin
			prod_s1 <= PROD_W'(elapsed_q) * PROD_W'(SEC_MAGIC);
		end
	end

	// Ring store: one write port, one registered read at the write pointer.
	always_ff @(posedge clk) begin
		if (cmd.ring_upd) begin
			ring_mem[wp_q] <= div_quot;
		end
		slot_rd_q <= ring_mem[wp_q];
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_q.rolling_average <= avg_q;
			out_q.window_closed   <= cmd.out_closed;
		end
	end

	assign out_data      = out_q;
	assign out_valid     = out_valid_q;
	assign stat.secs_nz  = (secs != '0);
	assign stat.div_done = div_done;
	assign stat.out_busy = out_valid_q & out_stall;

endmodule

FILE: src/wrm_ctrl.sv
// Controller state machine sequencing one input beat through the datapath.
// Depends on wrm_pkg.
module wrm_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_stall,
	input  wrm_pkg::stat_t stat,
	output wrm_pkg::cmd_t  cmd
);
	import wrm_pkg::*;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_MUL  = 3'd1;
	localparam logic [2:0] ST_CHK  = 3'd2;
	localparam logic [2:0] ST_DIV1 = 3'd3;
	localparam logic [2:0] ST_DIV2 = 3'd4;
	localparam logic [2:0] ST_FIN  = 3'd5;

	logic [2:0] state_q;
	logic [2:0] state_d;
	logic       closed_q;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		cmd.out_closed = closed_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.accept = 1'b1;
					state_d    = ST_MUL;
				end
			end
			ST_MUL: begin
				cmd.mul_en = 1'b1;
				state_d    = ST_CHK;
			end
			ST_CHK: begin
				if (stat.secs_nz) begin
					cmd.div1_start = 1'b1;
					state_d        = ST_DIV1;
				end else begin
					state_d = ST_FIN;
				end
			end
			ST_DIV1: begin
				if (stat.div_done) begin
					cmd.ring_upd = 1'b1;
					state_d      = ST_DIV2;
				end
			end
			ST_DIV2: begin
				if (stat.div_done) begin
					cmd.close = 1'b1;
					state_d   = ST_FIN;
				end
			end
			ST_FIN: begin
				if (!stat.out_busy) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			closed_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CHK) begin
				closed_q <= stat.secs_nz;
			end
		end
	end

	assign in_stall = (state_q != ST_IDLE);

endmodule

FILE: src/windowed_rate_average_meter_top.sv
// Top level of the windowed rate average meter: controller plus datapath.
// Depends on wrm_pkg, wrm_ctrl and wrm_dp.
//
//   Channel   Direction  Handshake             Beat contents
//   in        sink       in_valid / in_stall   in_data: sample_value, now_ms
//   out       source     out_valid / out_stall out_data: rolling_average, window_closed
//   cfg       sink       cfg_we                cfg_wdata: per_time_unit
//
// A beat that closes no interval is accepted, turned into whole seconds and checked, and then
// its result is loaded. A closing beat makes two further passes through the shared bit-serial
// divider before loading: first the interval value, then the new average.
// Reset is asynchronous and active low; it clears the interval, the ring counters and the
// average and selects rate mode. The ring store is not cleared, as only written slots are read.
// A result waiting under out_stall holds back only the loading of the next result.
module windowed_rate_average_meter_top (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic               cfg_wdata,
	input  logic               in_valid,
	output logic               in_stall,
	input  wrm_pkg::in_beat_t  in_data,
	output logic               out_valid,
	input  logic               out_stall,
	output wrm_pkg::out_beat_t out_data
);
	import wrm_pkg::*;

	// Commands from the controller and status back from the datapath.
	cmd_t  cmd;
	stat_t stat;

	// The controller steps each beat through accumulate, seconds, divisions and output.
	wrm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.stat     (stat),
		.cmd      (cmd)
	);

	// The datapath holds all arithmetic, the ring store and the output register.
	wrm_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.in_data   (in_data),
		.out_data  (out_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cmd       (cmd),
		.stat      (stat)
	);

endmodule

FILE: dv/windowed_rate_average_meter_top_tb.sv
// Self-checking testbench for windowed_rate_average_meter_top: directed and random beats
// against a scoreboard that tracks the interval, the ring and the rolling average itself.
// Depends on wrm_pkg and the windowed_rate_average_meter_top RTL only.
module windowed_rate_average_meter_top_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import wrm_pkg::*;

	// A closing beat finishes its work inside the block well within this, so it covers any work in flight.
	localparam int SETTLE_CYCLES   = 200;
	localparam int PHASES          = 8;
	localparam int BEATS_PER_PHASE = 204;
	localparam int REPORT_LIMIT    = 10;

	localparam bit MODE_PER_SAMPLE = 1'b0;
	localparam bit MODE_RATE       = 1'b1;

	// The scoreboard keeps its own copy of the interval and the ring. Each accepted input beat
	// advances that copy and queues the result beat the block must send back for it.
	class rate_avg_scoreboard;
		bit          rate_mode;
		logic [63:0] interval_sum;
		logic [31:0] sample_count;
		logic [31:0] interval_start;
		logic [63:0] slots [WINDOW_SLOTS];
		int          fill;
		int          wr_slot;
		logic [63:0] ring_total;
		logic [63:0] average;
		out_beat_t   expected_averages [$];
		int          failures;

		function new();
			rate_mode      = MODE_RATE;
			interval_sum   = '0;
			sample_count   = '0;
			interval_start = '0;
			fill           = 0;
			wr_slot        = 0;
			ring_total     = '0;
			average        = '0;
			failures       = 0;
			foreach (slots[i])
				slots[i] = '0;
		endfunction

		function void note_sample(in_beat_t b);
			logic [31:0] elapsed;
			logic [31:0] secs;
			logic [63:0] value;
			out_beat_t   predicted;
			interval_sum += 64'(b.sample_value);
			if (sample_count != '1)
				sample_count++;
			// The elapsed time wraps with the millisecond counter.
			elapsed = b.now_ms - interval_start;
			secs    = elapsed / 32'(TICKS_PER_SECOND);
			predicted.window_closed = 1'b0;
			if (secs != 0) begin
				value = interval_sum / (rate_mode ? 64'(secs) : 64'(sample_count));
				// Once the ring is full the oldest slot leaves the total as the new one enters.
				if (fill < WINDOW_SLOTS) begin
					ring_total += value;
					fill++;
				end else begin
					ring_total = ring_total - slots[wr_slot] + value;
				end
				slots[wr_slot] = value;
				wr_slot = (wr_slot == WINDOW_SLOTS - 1) ? 0 : wr_slot + 1;
				average = ring_total / 64'(fill);
				interval_start = b.now_ms;
				interval_sum   = '0;
				sample_count   = '0;
				predicted.window_closed = 1'b1;
			end
			predicted.rolling_average = average;
			expected_averages = {expected_averages, predicted};
		endfunction

		function void check_result(out_beat_t got);
			out_beat_t want;
			if (expected_averages.size() == 0) begin
				failures++;
				if (failures <= REPORT_LIMIT)
					$display("unexpected result beat: average %0d closed %0b",
						got.rolling_average, got.window_closed);
				return;
			end
			want = expected_averages.pop_front();
			if (got.rolling_average !== want.rolling_average ||
					got.window_closed !== want.window_closed) begin
				failures++;
				if (failures <= REPORT_LIMIT)
					$display("mismatch: average %0d closed %0b, expected average %0d closed %0b",
						got.rolling_average, got.window_closed,
						want.rolling_average, want.window_closed);
			end
		endfunction

		function int pending();
			return expected_averages.size();
		endfunction
	endclass

	logic      clk;
	logic      arst_n;
	logic      cfg_we;
	logic      cfg_wdata;
	logic      in_valid;
	logic      in_stall;
	in_beat_t  in_data;
	logic      out_valid;
	logic      out_stall;
	out_beat_t out_data;

	rate_avg_scoreboard sb;
	int                 send_idle_pct;
	int                 stall_pct;
	logic [31:0]        stream_ms;

	windowed_rate_average_meter_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// A generous ceiling: even with every beat closing an interval and both sides idling
	// heavily, a correct run ends well inside this.
	initial begin
		#30_000_000;
		$display("[windowed_rate_average_meter_top] ERROR");
		$finish;
	end

	// Both monitors sample just after the edge, so they see the values that decided the
	// handshake at that edge, before any of this edge's updates land.
	always @(posedge clk) begin
		if (arst_n && in_valid && !in_stall)
			sb.note_sample(in_data);
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			sb.check_result(out_data);
	end

	// The receiver stalls at random, at the rate the current phase asks for.
	always @(posedge clk) begin
		out_stall <= ($urandom_range(99) < stall_pct);
	end

	// Offers one beat and holds it until the block takes it. The sender may first sit idle
	// for a few cycles; valid is never lowered and raised again within one edge.
	task automatic send_sample(input logic [31:0] value, input logic [31:0] now);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid              <= 1'b1;
		in_data.sample_value  <= value;
		in_data.now_ms        <= now;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
	endtask

	// Withdraws the sender, waits until every expected result has come back, then lets any
	// leftover work settle.
	task automatic drain();
		in_valid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// The mode register is only written with the block idle, so the scoreboard can switch
	// its own copy at the same moment.
	task automatic write_mode(input bit mode);
		drain();
		cfg_we    <= 1'b1;
		cfg_wdata <= mode;
		@(posedge clk);
		cfg_we    <= 1'b0;
		sb.rate_mode = mode;
	endtask

	initial begin
		int          pick;
		logic [31:0] value;

		sb = new();
		send_idle_pct = 0;
		stall_pct     = 0;
		stream_ms     = 32'd10_000;
		arst_n    <= 1'b0;
		cfg_we    <= 1'b0;
		cfg_wdata <= 1'b0;
		in_valid  <= 1'b0;
		in_data   <= '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed beats in rate mode, which is the state left by reset. The first interval
		// starts at time zero, so nothing closes before the first whole second.
		send_sample(32'd0, 32'd500);
		send_sample(32'hFFFF_FFFF, 32'd999);
		send_sample(32'hFFFF_FFFF, 32'd1000);
		send_sample(32'd0, 32'd1000);
		send_sample(32'd12345, 32'd4000);
		// A near-largest elapsed time, then a close across the wrap of the millisecond counter.
		send_sample(32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_sample(32'd1, 32'h0000_01F3);
		send_sample(32'd7, 32'h0000_03E8);
		// An interval whose sum is zero closes to a value of zero.
		send_sample(32'd0, 32'h0000_07CF);
		send_sample(32'd0, 32'h0000_07D0);

		// Directed beats in per-sample mode: several samples share one interval.
		write_mode(MODE_PER_SAMPLE);
		send_sample(32'd100, 32'd3000);
		send_sample(32'd200, 32'd3100);
		send_sample(32'hAAAA_AAAA, 32'd3500);
		send_sample(32'h5555_5555, 32'd4100);
		send_sample(32'hFFFF_FFFF, 32'd9000);
		send_sample(32'hFFFF_FFFF, 32'd9999);
		send_sample(32'hFFFF_FFFF, 32'd10_000);

		// Random phases. Time mostly moves forward in small steps, so that most intervals
		// collect several samples and the ring fills and wraps many times; now and then it
		// leaps ahead, jumps anywhere or steps backwards.
		for (int p = 0; p < PHASES; p++) begin
			write_mode(p[0] ? MODE_PER_SAMPLE : MODE_RATE);
			case (p % 4)
				0: begin
					send_idle_pct = 0;
					stall_pct     = 0;
				end
				1: begin
					send_idle_pct = 76;
					stall_pct     = 0;
				end
				2: begin
					send_idle_pct = 0;
					stall_pct     = 76;
				end
				default: begin
					send_idle_pct = 20;
					stall_pct     = 20;
				end
			endcase
			// Half way through, ordinary traffic runs across the wrap of the time counter.
			if (p == PHASES / 2)
				stream_ms = 32'hFFFF_F000;
			repeat (BEATS_PER_PHASE) begin
				pick = $urandom_range(99);
				if (pick < 70)
					stream_ms += $urandom_range(350);
				else if (pick < 85)
					stream_ms += $urandom_range(1100, 900);
				else if (pick < 93)
					stream_ms += $urandom_range(60_000, 1000);
				else if (pick < 97)
					stream_ms = $urandom;
				else
					stream_ms -= $urandom_range(2000);

				pick = $urandom_range(99);
				if (pick < 25)
					value = $urandom;
				else if (pick < 50)
					value = $urandom_range(255);
				else if (pick < 65)
					value = 32'hFFFF_FFFF;
				else if (pick < 75)
					value = 32'd0;
				else
					value = $urandom >> $urandom_range(31);
				send_sample(value, stream_ms);
			end
			in_valid <= 1'b0;
		end

		drain();
		if (sb.failures == 0 && sb.pending() == 0)
			$display("[windowed_rate_average_meter_top] OK");
		else
			$display("[windowed_rate_average_meter_top] ERROR");
		$finish;
	end

endmodule
